### rtl/pbts_pkg.sv
// Shared types, constants and helpers for the priority bitmap tick scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pbts_pkg;

    // Number of tasks (one per priority, last one is the idle task)
    localparam int TASK_COUNT  = 8;
    // Width of each per-task delay counter
    localparam int COUNT_WIDTH = 16;

    // Widths of the fields
    localparam int CMD_W   = 2;
    localparam int IDX_W   = 3;
    localparam int TICKS_W = 16;
    localparam int BITS_W  = 8;

    // Saturation value of a delay counter, held in 32 bits
    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELAY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Input beat
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [IDX_W-1:0]   task_index;
        logic [TICKS_W-1:0] delay_ticks;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic [IDX_W-1:0]  highest_ready;
        logic [BITS_W-1:0] ready_bits;
        logic              any_ready;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture the accepted input beat
        logic exec;   // apply the captured beat and register the result
    } t_dp_cmd;

    // Load value for a counter: saturates when the counter is narrower than the field
    function automatic logic [COUNT_WIDTH-1:0] load_value(input logic [TICKS_W-1:0] ticks);
        logic [31:0] t;
        t = {16'd0, ticks};
        if (t > COUNT_MAX) begin
            t = COUNT_MAX;
        end
        return COUNT_WIDTH'(t);
    endfunction

endpackage

`default_nettype wire

### rtl/pbts_ctrl.sv
// Controller state machine: input/output handshake and datapath sequencing.
`timescale 1ns / 1ps
`default_nettype none

module pbts_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output pbts_pkg::t_dp_cmd o_cmd
);
    import pbts_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic accept;
    logic out_free;

    // Output slot is free if empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_cmd.load  = accept;
    assign o_cmd.exec  = (r_state == S_EXEC);
    assign o_out_valid = r_out_valid;

    // Next state and output valid
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // No new beat is taken while one is executing
    a_no_accept_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> o_in_stall)
        else $error("input accepted during execute");

    // An accepted beat executes in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted beat did not execute");

    // The result register is empty when a result is written into it
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> !r_out_valid)
        else $error("result overwritten before delivery");

    // Execution always produces a result beat
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> r_out_valid)
        else $error("execute produced no result");

endmodule

`default_nettype wire

### rtl/pbts_datapath.sv
// Datapath: ready bitmap, delay counters, priority encoder and result register.
`timescale 1ns / 1ps
`default_nettype none

module pbts_datapath (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  pbts_pkg::t_dp_cmd  i_cmd,
    input  pbts_pkg::t_in_item i_in_data,
    output pbts_pkg::t_out_item o_out_data
);
    import pbts_pkg::*;

    t_in_item                r_item;
    logic [TASK_COUNT-1:0]   r_mask;
    logic [TASK_COUNT-1:0]   n_mask;
    logic [COUNT_WIDTH-1:0]  r_cnt [TASK_COUNT];
    logic [COUNT_WIDTH-1:0]  n_cnt [TASK_COUNT];
    logic [IDX_W-1:0]        r_winner;
    logic [IDX_W-1:0]        n_winner;
    logic [COUNT_WIDTH-1:0]  load_val;
    logic                    idx_ok;
    t_out_item               r_out;

    assign load_val   = load_value(r_item.delay_ticks);
    assign idx_ok     = {1'b0, r_item.task_index} < (IDX_W + 1)'(TASK_COUNT);
    assign o_out_data = r_out;

    // Command decode and counter update
    always_comb begin
        n_mask = r_mask;
        for (int i = 0; i < TASK_COUNT; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        unique case (r_item.command)
            CMD_CREATE: begin
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (idx_ok && r_item.task_index == IDX_W'(i)) begin
                        n_mask[i] = 1'b1;
                        n_cnt[i]  = load_val;
                    end
                end
            end
            CMD_DELAY: begin
                for (int i = 0; i < TASK_COUNT; i++) begin
                    if (idx_ok && r_item.task_index == IDX_W'(i)) begin
                        n_mask[i] = 1'b0;
                        n_cnt[i]  = load_val;
                    end
                end
            end
            CMD_TICK: begin
                // Count down all but the idle task, saturating at zero
                for (int i = 0; i < TASK_COUNT - 1; i++) begin
                    if (r_cnt[i] != '0) begin
                        n_cnt[i] = r_cnt[i] - COUNT_WIDTH'(1);
                    end
                    if (r_cnt[i] <= COUNT_WIDTH'(1)) begin
                        n_mask[i] = 1'b1;
                    end
                end
                n_mask[TASK_COUNT-1] = 1'b1;
            end
            default: begin
                // unused command leaves state alone
            end
        endcase
    end

    // Lowest set bit wins; hold the previous winner on an empty bitmap
    always_comb begin
        n_winner = r_winner;
        for (int i = TASK_COUNT - 1; i >= 0; i--) begin
            if (n_mask[i]) begin
                n_winner = IDX_W'(i);
            end
        end
    end

    // Scheduler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_winner <= '0;
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            r_mask   <= n_mask;
            r_winner <= n_winner;
            for (int i = 0; i < TASK_COUNT; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // Captured input beat and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_out.highest_ready <= n_winner;
            r_out.ready_bits    <= BITS_W'(n_mask);
            r_out.any_ready     <= (n_mask != '0);
        end
    end

endmodule

`default_nettype wire

### rtl/priority_bitmap_tick_scheduler_core.sv
// An accepted beat is captured and executes in the next cycle; its result beat is
// registered into the output register at the end of that execute cycle.
// Beats are not overlapped: each is accepted, then executed in a state that updates
// the bitmap, all counters and the winner together, with the input stalled.
// A result waiting in the output register stalls the input until it is taken.
// Reset (synchronous, active low): bitmap, counters and winner clear to zero.
`timescale 1ns / 1ps
`default_nettype none

module priority_bitmap_tick_scheduler_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  pbts_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output pbts_pkg::t_out_item o_out_data
);
    import pbts_pkg::*;

    t_dp_cmd cmd;

    // Sequencer
    pbts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Scheduler datapath
    pbts_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire
